FILE: design/dfsc_pkg.sv
// shared types and constants for the delta frame skip/copy decoder
`default_nettype none

package dfsc_pkg;

	localparam int BYTES_PER_PIXEL = 4;
	localparam int SIDE_W          = 13;
	localparam int FRAMES_W        = 16;
	localparam int AREA_W          = 2 * SIDE_W;
	localparam int POS_W           = AREA_W + 1;
	localparam int PAY_W           = 32;
	localparam int COUNT_W         = 16;
	localparam int INDEX_W         = 24;
	localparam int PIXEL_W         = 32;
	localparam int DATA_W          = 8;
	localparam int PADDR_W         = 4;
	localparam int PDATA_W         = 32;
	localparam int OUT_DATA_W      = 80;

	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_FRAMES = 2'd2;

	localparam logic [7:0] TYPE_KEY   = 8'd0;
	localparam logic [7:0] TYPE_DELTA = 8'd1;

	typedef enum logic [1:0] {
		KIND_KEY   = 2'd0,
		KIND_DELTA = 2'd1,
		KIND_OTHER = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ERR_NONE    = 2'd0,
		ERR_SIZE    = 2'd1,
		ERR_OVERRUN = 2'd2,
		ERR_TYPE    = 2'd3
	} err_t;

	typedef struct packed {
		logic [AREA_W-1:0]   area;
		logic [FRAMES_W-1:0] frames;
	} cfg_t;

	typedef struct packed {
		logic                valid;
		logic                write_valid;
		logic [INDEX_W-1:0]  pixel_index;
		logic [PIXEL_W-1:0]  pixel_value;
		logic                frame_done;
		logic [FRAMES_W-1:0] frame_number;
		logic                animation_done;
		err_t                error_code;
	} result_t;

endpackage

`default_nettype wire

FILE: design/dfsc_cfg.sv
// apb register file with clamped frame area and frame count
`default_nettype none

module dfsc_cfg #(
	parameter int MAX_SIDE = 4096
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire  [dfsc_pkg::PADDR_W-1:0]  paddr,
	input  wire  [dfsc_pkg::PDATA_W-1:0]  pwdata,
	output logic [dfsc_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready,
	output dfsc_pkg::cfg_t                cfg
);
	import dfsc_pkg::*;

	localparam logic [16:0] MAX_SIDE_C = 17'(MAX_SIDE);

	logic [SIDE_W-1:0]   width_q;
	logic [SIDE_W-1:0]   height_q;
	logic [FRAMES_W-1:0] frames_q;
	logic [AREA_W-1:0]   area_q;
	logic [SIDE_W-1:0]   width_c;
	logic [SIDE_W-1:0]   height_c;
	logic                wr_en;
	logic [1:0]          reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;

	function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if ({4'b0, v} > MAX_SIDE_C) begin
			r = SIDE_W'(MAX_SIDE_C);
		end else begin
			r = v;
		end
		return r;
	endfunction

	assign width_c  = clamp_side(width_q);
	assign height_c = clamp_side(height_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIDE_W'(1);
			height_q <= SIDE_W'(1);
			frames_q <= FRAMES_W'(1);
			area_q   <= AREA_W'(1);
		end else begin
			if (wr_en) begin
				unique case (reg_sel)
					REG_WIDTH:  width_q  <= pwdata[SIDE_W-1:0];
					REG_HEIGHT: height_q <= pwdata[SIDE_W-1:0];
					REG_FRAMES: frames_q <= pwdata[FRAMES_W-1:0];
					default: ;
				endcase
			end
			area_q <= width_c * height_c;
		end
	end

	always_comb begin
		unique case (reg_sel)
			REG_WIDTH:  prdata = PDATA_W'(width_q);
			REG_HEIGHT: prdata = PDATA_W'(height_q);
			REG_FRAMES: prdata = PDATA_W'(frames_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg.area   = area_q;
	assign cfg.frames = (frames_q == '0) ? FRAMES_W'(1) : frames_q;

endmodule

`default_nettype wire

FILE: design/dfsc_parse.sv
// frame stream parser: per-byte state update and result decode
`default_nettype none

module dfsc_parse (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          step,
	input  wire  [dfsc_pkg::DATA_W-1:0]  stream_byte,
	input  wire  dfsc_pkg::cfg_t         cfg,
	output dfsc_pkg::result_t            res
);
	import dfsc_pkg::*;

	typedef enum logic [2:0] {
		PH_TYPE  = 3'd0,
		PH_SIZE  = 3'd1,
		PH_KEY   = 3'd2,
		PH_DHDR  = 3'd3,
		PH_DCOPY = 3'd4,
		PH_SKIP  = 3'd5
	} phase_t;

	phase_t              phase_q, phase_n;
	logic [1:0]          cnt_q, cnt_n;
	kind_t               kind_q, kind_n;
	logic [PAY_W-1:0]    pay_q, pay_n;
	logic [POS_W-1:0]    pos_q, pos_n;
	logic [COUNT_W-1:0]  skip_q, skip_n;
	logic [COUNT_W-1:0]  copy_q, copy_n;
	logic [23:0]         part_q, part_n;
	logic [FRAMES_W-1:0] cur_q, cur_n;

	logic [PAY_W-1:0]    pay_asm;
	logic [PAY_W-1:0]    pay_dec;
	logic [23:0]         part_asm;
	logic [POS_W-1:0]    pos_inc;
	logic [POS_W-1:0]    pos_skip;
	logic [POS_W:0]      run_end;
	logic [POS_W-1:0]    area_x;
	logic [COUNT_W-1:0]  copy_full;
	logic [COUNT_W-1:0]  copy_dec;
	logic [PIXEL_W-1:0]  pix;
	logic                in_frame;
	logic                anim;
	logic [FRAMES_W:0]   cur_inc;
	err_t                size_err;
	err_t                run_err;

	always_comb begin
		pay_asm  = pay_q;
		part_asm = part_q;
		unique case (cnt_q)
			2'd0: begin
				pay_asm[7:0]   = stream_byte;
				part_asm[7:0]  = stream_byte;
			end
			2'd1: begin
				pay_asm[15:8]  = stream_byte;
				part_asm[15:8] = stream_byte;
			end
			2'd2: begin
				pay_asm[23:16]  = stream_byte;
				part_asm[23:16] = stream_byte;
			end
			default: begin
				pay_asm[31:24] = stream_byte;
			end
		endcase
	end

	assign area_x    = POS_W'(cfg.area);
	assign pay_dec   = pay_q - PAY_W'(1);
	assign pos_inc   = (&pos_q) ? pos_q : pos_q + POS_W'(1);
	assign pos_skip  = pos_q + POS_W'(skip_q);
	assign copy_full = {stream_byte, copy_q[7:0]};
	assign copy_dec  = copy_q - COUNT_W'(1);
	assign run_end   = {1'b0, pos_skip} + (POS_W+1)'(copy_full);
	assign pix       = {stream_byte, part_q};
	assign in_frame  = pos_q < area_x;
	assign cur_inc   = {1'b0, cur_q} + (FRAMES_W+1)'(1);
	assign anim      = cur_inc >= {1'b0, cfg.frames};
	assign size_err  = (pay_asm != PAY_W'({cfg.area, 2'b00})) ? ERR_SIZE : ERR_NONE;
	assign run_err   = (run_end > (POS_W+1)'(cfg.area)) ? ERR_OVERRUN : ERR_NONE;

	always_comb begin
		phase_n = phase_q;
		cnt_n   = cnt_q;
		kind_n  = kind_q;
		pay_n   = pay_q;
		pos_n   = pos_q;
		skip_n  = skip_q;
		copy_n  = copy_q;
		part_n  = part_q;
		cur_n   = cur_q;

		res                = '0;
		res.frame_number   = cur_q;
		res.error_code     = ERR_NONE;

		unique case (phase_q)
			PH_TYPE: begin
				if (stream_byte == TYPE_KEY) begin
					kind_n = KIND_KEY;
				end else if (stream_byte == TYPE_DELTA) begin
					kind_n = KIND_DELTA;
				end else begin
					kind_n         = KIND_OTHER;
					res.valid      = 1'b1;
					res.error_code = ERR_TYPE;
				end
				phase_n = PH_SIZE;
				cnt_n   = '0;
				pay_n   = '0;
			end
			PH_SIZE: begin
				pay_n = pay_asm;
				if (cnt_q != 2'd3) begin
					cnt_n = cnt_q + 2'd1;
				end else begin
					cnt_n  = '0;
					pos_n  = '0;
					part_n = '0;
					unique case (kind_q)
						KIND_KEY: begin
							if (pay_asm == '0) begin
								res.valid      = 1'b1;
								res.frame_done = 1'b1;
								res.error_code = size_err;
							end else begin
								phase_n = PH_KEY;
								if (size_err != ERR_NONE) begin
									res.valid      = 1'b1;
									res.error_code = size_err;
								end
							end
						end
						KIND_DELTA: begin
							phase_n = PH_DHDR;
							skip_n  = '0;
							copy_n  = '0;
						end
						default: begin
							if (pay_asm == '0) begin
								res.valid      = 1'b1;
								res.frame_done = 1'b1;
							end else begin
								phase_n = PH_SKIP;
							end
						end
					endcase
				end
			end
			PH_KEY: begin
				pay_n = pay_dec;
				if (cnt_q != 2'd3) begin
					part_n = part_asm;
					cnt_n  = cnt_q + 2'd1;
				end else begin
					res.write_valid = in_frame;
					res.pixel_index = INDEX_W'(pos_q);
					res.pixel_value = pix;
					pos_n  = pos_inc;
					part_n = '0;
					cnt_n  = '0;
				end
				if (pay_dec == '0) begin
					res.valid      = 1'b1;
					res.frame_done = 1'b1;
				end else if (res.write_valid) begin
					res.valid = 1'b1;
				end
			end
			PH_DHDR: begin
				unique case (cnt_q)
					2'd0: skip_n = COUNT_W'(stream_byte);
					2'd1: skip_n = {stream_byte, skip_q[7:0]};
					2'd2: copy_n = COUNT_W'(stream_byte);
					default: begin
						copy_n = copy_full;
						pos_n  = pos_skip;
						part_n = '0;
					end
				endcase
				cnt_n = cnt_q + 2'd1;
				if (cnt_q == 2'd3) begin
					res.error_code = run_err;
					if (copy_full == '0) begin
						if (pos_skip >= area_x) begin
							res.valid      = 1'b1;
							res.frame_done = 1'b1;
						end else if (run_err != ERR_NONE) begin
							res.valid = 1'b1;
						end
					end else begin
						phase_n = PH_DCOPY;
						if (run_err != ERR_NONE) begin
							res.valid = 1'b1;
						end
					end
				end
			end
			PH_DCOPY: begin
				if (cnt_q != 2'd3) begin
					part_n = part_asm;
					cnt_n  = cnt_q + 2'd1;
				end else begin
					res.write_valid = in_frame;
					res.pixel_index = INDEX_W'(pos_q);
					res.pixel_value = pix;
					pos_n  = pos_inc;
					part_n = '0;
					cnt_n  = '0;
					copy_n = copy_dec;
					if (copy_dec == '0 && pos_inc >= area_x) begin
						res.valid      = 1'b1;
						res.frame_done = 1'b1;
					end else begin
						if (copy_dec == '0) begin
							phase_n = PH_DHDR;
						end
						res.valid = in_frame;
					end
				end
			end
			PH_SKIP: begin
				pay_n = pay_dec;
				if (pay_dec == '0) begin
					res.valid      = 1'b1;
					res.frame_done = 1'b1;
				end
			end
			default: begin
				phase_n = PH_TYPE;
				cnt_n   = '0;
			end
		endcase

		if (!res.write_valid) begin
			res.pixel_index = '0;
			res.pixel_value = '0;
		end
		if (res.frame_done) begin
			res.animation_done = anim;
			cur_n   = anim ? '0 : cur_inc[FRAMES_W-1:0];
			phase_n = PH_TYPE;
			cnt_n   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			cnt_q   <= '0;
			kind_q  <= KIND_KEY;
			pay_q   <= '0;
			pos_q   <= '0;
			skip_q  <= '0;
			copy_q  <= '0;
			part_q  <= '0;
			cur_q   <= '0;
		end else if (step) begin
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
			kind_q  <= kind_n;
			pay_q   <= pay_n;
			pos_q   <= pos_n;
			skip_q  <= skip_n;
			copy_q  <= copy_n;
			part_q  <= part_n;
			cur_q   <= cur_n;
		end
	end

endmodule

`default_nettype wire

FILE: design/delta_frame_skip_copy_decoder_core.sv
// top level of the delta frame skip/copy decoder
// usage:
//   the slave stream takes the encoded animation one byte per transfer in
//   s_tdata; the master stream gives one result per event: a frame store
//   write (m_tuser high), a frame close (m_tlast high) or an error report.
//   frame geometry and frame count are set over the apb port while idle.
// decode: a taken byte waits in the byte register until the parser steps;
//   its result, if any, is registered then and shown on the master side.
// throughput: one byte per cycle, sustained; the byte register and the
//   result register each hold one item, so the parser advances every cycle
//   that the result register is empty or being drained.
// stall: while a result waits on m_tready the parser holds, the byte
//   register fills, and s_tready drops until the result is taken.
// reset: arst_n clears both stages, the parser state and the frame counter;
//   width, height and frame count return to 1. the first byte after reset
//   is taken as a frame type byte.
// the frame area product is registered in the cycle after a register write.
`default_nettype none

module delta_frame_skip_copy_decoder_core #(
	parameter int MAX_SIDE = 4096
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// apb configuration
	input  wire                              psel,
	input  wire                              penable,
	input  wire                              pwrite,
	input  wire  [dfsc_pkg::PADDR_W-1:0]     paddr,
	input  wire  [dfsc_pkg::PDATA_W-1:0]     pwdata,
	output logic [dfsc_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready,
	// byte stream in
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [dfsc_pkg::DATA_W-1:0]      s_tdata,   // [7:0] stream_byte
	// result stream out
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// [23:0] pixel_index, [55:24] pixel_value, [71:56] frame_number,
	// [72] animation_done, [74:73] error_code, [79:75] zero
	output logic [dfsc_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic                             m_tuser,   // write_valid
	output logic                             m_tlast    // frame_done
);
	import dfsc_pkg::*;

	cfg_t              cfg;
	result_t           res;
	logic              in_v_s1;
	logic [DATA_W-1:0] in_byte_s1;
	logic              adv;
	logic              step;
	logic              out_v_s2;
	result_t           out_s2;

	dfsc_cfg #(
		.MAX_SIDE (MAX_SIDE)
	) u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	dfsc_parse u_parse (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.stream_byte (in_byte_s1),
		.cfg         (cfg),
		.res         (res)
	);

	assign adv      = !out_v_s2 || m_tready;
	assign step     = in_v_s1 && adv;
	assign s_tready = !in_v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_v_s1 <= 1'b0;
		end else if (s_tready) begin
			in_v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_s2 <= 1'b0;
		end else if (adv) begin
			out_v_s2 <= step && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res.valid) begin
			out_s2 <= res;
		end
	end

	assign m_tvalid = out_v_s2;
	assign m_tuser  = out_s2.write_valid;
	assign m_tlast  = out_s2.frame_done;
	assign m_tdata  = {5'b0, out_s2.error_code, out_s2.animation_done,
		out_s2.frame_number, out_s2.pixel_value, out_s2.pixel_index};

endmodule

`default_nettype wire

FILE: design/dfsc_checker.sv
// port-level checks for the decoder, bound to the top level
`default_nettype none

module dfsc_checker (
	input wire                              clk,
	input wire                              arst_n,
	input wire                              m_tvalid,
	input wire                              m_tready,
	input wire [dfsc_pkg::OUT_DATA_W-1:0]   m_tdata,
	input wire                              m_tuser,
	input wire                              m_tlast
);
	import dfsc_pkg::*;

	// a result held under backpressure stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");

	// non-write results carry zero index and value
	a_nowrite_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[55:0] == '0)
		else $error("pixel fields set without a write");

	// end of animation only on a frame close
	a_anim_close: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[72] |-> m_tlast)
		else $error("animation done without frame close");

	// unknown type is flagged on the type byte alone
	a_type_err: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[74:73] == ERR_TYPE |-> !m_tuser && !m_tlast)
		else $error("type error on a write or close");

	// pixel writes never carry an error
	a_write_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[74:73] == ERR_NONE)
		else $error("write with error code");

endmodule

bind delta_frame_skip_copy_decoder_core dfsc_checker u_dfsc_checker (.*);

`default_nettype wire
